@@ hw/rtl/aes128_pkg.sv @@
// Package: AES-128 constants, S-box and round helper functions.
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned KeyRoundW = 4;
  localparam int unsigned WordW = 64;

  localparam logic ActLoad = 1'b0;
  localparam logic ActEncrypt = 1'b1;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] s;
    case (a)
      8'h00: s = 8'h63; 8'h01: s = 8'h7c; 8'h02: s = 8'h77; 8'h03: s = 8'h7b;
      8'h04: s = 8'hf2; 8'h05: s = 8'h6b; 8'h06: s = 8'h6f; 8'h07: s = 8'hc5;
      8'h08: s = 8'h30; 8'h09: s = 8'h01; 8'h0a: s = 8'h67; 8'h0b: s = 8'h2b;
      8'h0c: s = 8'hfe; 8'h0d: s = 8'hd7; 8'h0e: s = 8'hab; 8'h0f: s = 8'h76;
      8'h10: s = 8'hca; 8'h11: s = 8'h82; 8'h12: s = 8'hc9; 8'h13: s = 8'h7d;
      8'h14: s = 8'hfa; 8'h15: s = 8'h59; 8'h16: s = 8'h47; 8'h17: s = 8'hf0;
      8'h18: s = 8'had; 8'h19: s = 8'hd4; 8'h1a: s = 8'ha2; 8'h1b: s = 8'haf;
      8'h1c: s = 8'h9c; 8'h1d: s = 8'ha4; 8'h1e: s = 8'h72; 8'h1f: s = 8'hc0;
      8'h20: s = 8'hb7; 8'h21: s = 8'hfd; 8'h22: s = 8'h93; 8'h23: s = 8'h26;
      8'h24: s = 8'h36; 8'h25: s = 8'h3f; 8'h26: s = 8'hf7; 8'h27: s = 8'hcc;
      8'h28: s = 8'h34; 8'h29: s = 8'ha5; 8'h2a: s = 8'he5; 8'h2b: s = 8'hf1;
      8'h2c: s = 8'h71; 8'h2d: s = 8'hd8; 8'h2e: s = 8'h31; 8'h2f: s = 8'h15;
      8'h30: s = 8'h04; 8'h31: s = 8'hc7; 8'h32: s = 8'h23; 8'h33: s = 8'hc3;
      8'h34: s = 8'h18; 8'h35: s = 8'h96; 8'h36: s = 8'h05; 8'h37: s = 8'h9a;
      8'h38: s = 8'h07; 8'h39: s = 8'h12; 8'h3a: s = 8'h80; 8'h3b: s = 8'he2;
      8'h3c: s = 8'heb; 8'h3d: s = 8'h27; 8'h3e: s = 8'hb2; 8'h3f: s = 8'h75;
      8'h40: s = 8'h09; 8'h41: s = 8'h83; 8'h42: s = 8'h2c; 8'h43: s = 8'h1a;
      8'h44: s = 8'h1b; 8'h45: s = 8'h6e; 8'h46: s = 8'h5a; 8'h47: s = 8'ha0;
      8'h48: s = 8'h52; 8'h49: s = 8'h3b; 8'h4a: s = 8'hd6; 8'h4b: s = 8'hb3;
      8'h4c: s = 8'h29; 8'h4d: s = 8'he3; 8'h4e: s = 8'h2f; 8'h4f: s = 8'h84;
      8'h50: s = 8'h53; 8'h51: s = 8'hd1; 8'h52: s = 8'h00; 8'h53: s = 8'hed;
      8'h54: s = 8'h20; 8'h55: s = 8'hfc; 8'h56: s = 8'hb1; 8'h57: s = 8'h5b;
      8'h58: s = 8'h6a; 8'h59: s = 8'hcb; 8'h5a: s = 8'hbe; 8'h5b: s = 8'h39;
      8'h5c: s = 8'h4a; 8'h5d: s = 8'h4c; 8'h5e: s = 8'h58; 8'h5f: s = 8'hcf;
      8'h60: s = 8'hd0; 8'h61: s = 8'hef; 8'h62: s = 8'haa; 8'h63: s = 8'hfb;
      8'h64: s = 8'h43; 8'h65: s = 8'h4d; 8'h66: s = 8'h33; 8'h67: s = 8'h85;
      8'h68: s = 8'h45; 8'h69: s = 8'hf9; 8'h6a: s = 8'h02; 8'h6b: s = 8'h7f;
      8'h6c: s = 8'h50; 8'h6d: s = 8'h3c; 8'h6e: s = 8'h9f; 8'h6f: s = 8'ha8;
      8'h70: s = 8'h51; 8'h71: s = 8'ha3; 8'h72: s = 8'h40; 8'h73: s = 8'h8f;
      8'h74: s = 8'h92; 8'h75: s = 8'h9d; 8'h76: s = 8'h38; 8'h77: s = 8'hf5;
      8'h78: s = 8'hbc; 8'h79: s = 8'hb6; 8'h7a: s = 8'hda; 8'h7b: s = 8'h21;
      8'h7c: s = 8'h10; 8'h7d: s = 8'hff; 8'h7e: s = 8'hf3; 8'h7f: s = 8'hd2;
      8'h80: s = 8'hcd; 8'h81: s = 8'h0c; 8'h82: s = 8'h13; 8'h83: s = 8'hec;
      8'h84: s = 8'h5f; 8'h85: s = 8'h97; 8'h86: s = 8'h44; 8'h87: s = 8'h17;
      8'h88: s = 8'hc4; 8'h89: s = 8'ha7; 8'h8a: s = 8'h7e; 8'h8b: s = 8'h3d;
      8'h8c: s = 8'h64; 8'h8d: s = 8'h5d; 8'h8e: s = 8'h19; 8'h8f: s = 8'h73;
      8'h90: s = 8'h60; 8'h91: s = 8'h81; 8'h92: s = 8'h4f; 8'h93: s = 8'hdc;
      8'h94: s = 8'h22; 8'h95: s = 8'h2a; 8'h96: s = 8'h90; 8'h97: s = 8'h88;
      8'h98: s = 8'h46; 8'h99: s = 8'hee; 8'h9a: s = 8'hb8; 8'h9b: s = 8'h14;
      8'h9c: s = 8'hde; 8'h9d: s = 8'h5e; 8'h9e: s = 8'h0b; 8'h9f: s = 8'hdb;
      8'ha0: s = 8'he0; 8'ha1: s = 8'h32; 8'ha2: s = 8'h3a; 8'ha3: s = 8'h0a;
      8'ha4: s = 8'h49; 8'ha5: s = 8'h06; 8'ha6: s = 8'h24; 8'ha7: s = 8'h5c;
      8'ha8: s = 8'hc2; 8'ha9: s = 8'hd3; 8'haa: s = 8'hac; 8'hab: s = 8'h62;
      8'hac: s = 8'h91; 8'had: s = 8'h95; 8'hae: s = 8'he4; 8'haf: s = 8'h79;
      8'hb0: s = 8'he7; 8'hb1: s = 8'hc8; 8'hb2: s = 8'h37; 8'hb3: s = 8'h6d;
      8'hb4: s = 8'h8d; 8'hb5: s = 8'hd5; 8'hb6: s = 8'h4e; 8'hb7: s = 8'ha9;
      8'hb8: s = 8'h6c; 8'hb9: s = 8'h56; 8'hba: s = 8'hf4; 8'hbb: s = 8'hea;
      8'hbc: s = 8'h65; 8'hbd: s = 8'h7a; 8'hbe: s = 8'hae; 8'hbf: s = 8'h08;
      8'hc0: s = 8'hba; 8'hc1: s = 8'h78; 8'hc2: s = 8'h25; 8'hc3: s = 8'h2e;
      8'hc4: s = 8'h1c; 8'hc5: s = 8'ha6; 8'hc6: s = 8'hb4; 8'hc7: s = 8'hc6;
      8'hc8: s = 8'he8; 8'hc9: s = 8'hdd; 8'hca: s = 8'h74; 8'hcb: s = 8'h1f;
      8'hcc: s = 8'h4b; 8'hcd: s = 8'hbd; 8'hce: s = 8'h8b; 8'hcf: s = 8'h8a;
      8'hd0: s = 8'h70; 8'hd1: s = 8'h3e; 8'hd2: s = 8'hb5; 8'hd3: s = 8'h66;
      8'hd4: s = 8'h48; 8'hd5: s = 8'h03; 8'hd6: s = 8'hf6; 8'hd7: s = 8'h0e;
      8'hd8: s = 8'h61; 8'hd9: s = 8'h35; 8'hda: s = 8'h57; 8'hdb: s = 8'hb9;
      8'hdc: s = 8'h86; 8'hdd: s = 8'hc1; 8'hde: s = 8'h1d; 8'hdf: s = 8'h9e;
      8'he0: s = 8'he1; 8'he1: s = 8'hf8; 8'he2: s = 8'h98; 8'he3: s = 8'h11;
      8'he4: s = 8'h69; 8'he5: s = 8'hd9; 8'he6: s = 8'h8e; 8'he7: s = 8'h94;
      8'he8: s = 8'h9b; 8'he9: s = 8'h1e; 8'hea: s = 8'h87; 8'heb: s = 8'he9;
      8'hec: s = 8'hce; 8'hed: s = 8'h55; 8'hee: s = 8'h28; 8'hef: s = 8'hdf;
      8'hf0: s = 8'h8c; 8'hf1: s = 8'ha1; 8'hf2: s = 8'h89; 8'hf3: s = 8'h0d;
      8'hf4: s = 8'hbf; 8'hf5: s = 8'he6; 8'hf6: s = 8'h42; 8'hf7: s = 8'h68;
      8'hf8: s = 8'h41; 8'hf9: s = 8'h99; 8'hfa: s = 8'h2d; 8'hfb: s = 8'h0f;
      8'hfc: s = 8'hb0; 8'hfd: s = 8'h54; 8'hfe: s = 8'hbb; 8'hff: s = 8'h16;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
  endfunction

  // Byte i of the 128-bit state sits at bits [127-8i -: 8].
  function automatic logic [127:0] sub_shift(input logic [127:0] st);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(st[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] st);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = st[127 - 32 * c -: 8];
      a1 = st[119 - 32 * c -: 8];
      a2 = st[111 - 32 * c -: 8];
      a3 = st[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

@@ hw/rtl/aes128_key_mem.sv @@
// Round key memory: two 64-bit banks (high and low half), one write, one registered read.
`timescale 1ns / 1ps
module aes128_key_mem #(
  parameter int unsigned ROUND_COUNT = aes128_pkg::RoundCount
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic                                wr_half_i,
  input  logic [$clog2(ROUND_COUNT+1)-1:0]   wr_addr_i,
  input  logic [aes128_pkg::WordW-1:0]        wr_data_i,
  input  logic [$clog2(ROUND_COUNT+1)-1:0]   rd_addr_i,
  output logic [2*aes128_pkg::WordW-1:0]      rd_key_o
);
  import aes128_pkg::*;

  localparam int unsigned Depth = ROUND_COUNT + 1;

  logic [WordW-1:0] mem_hi [Depth];
  logic [WordW-1:0] mem_lo [Depth];
  logic [WordW-1:0] rd_hi_q, rd_lo_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_half_i) begin
      mem_hi[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && wr_half_i) begin
      mem_lo[wr_addr_i] <= wr_data_i;
    end
    rd_hi_q <= mem_hi[rd_addr_i];
    rd_lo_q <= mem_lo[rd_addr_i];
  end

  assign rd_key_o = {rd_hi_q, rd_lo_q};

endmodule

@@ hw/rtl/aes128_block_encrypt_unit.sv @@
// Top level: AES-128 block encryption with a round key memory and one shared round unit.
// Each encrypt beat runs the key add and then ROUND_COUNT rounds before the result beat is offered;
// no new beat is taken until the unit is back in idle, and a full, stalled output register holds
//   the finished block back.
// Key-load beats are taken only while idle and leave the unit idle for the next beat.
// Reset clears the control state; the key memory holds unknown data until loaded.
`timescale 1ns / 1ps
module aes128_block_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = aes128_pkg::RoundCount
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [aes128_pkg::KeyRoundW-1:0] key_round_i,
  input  logic                             key_half_i,
  input  logic [aes128_pkg::WordW-1:0]     data_high_i,
  input  logic [aes128_pkg::WordW-1:0]     data_low_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [aes128_pkg::WordW-1:0]     cipher_high_o,
  output logic [aes128_pkg::WordW-1:0]     cipher_low_o
);
  import aes128_pkg::*;

  localparam int unsigned AddrW = $clog2(ROUND_COUNT + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] rnd_q, rnd_d;
  logic [127:0]     st_q, st_d;
  logic [127:0]     rkey;
  logic [AddrW-1:0] rd_addr;
  logic             in_acc, wr_en, last_rnd;
  logic [127:0]     ss;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_hi_q, out_hi_d, out_lo_q, out_lo_d;
  logic             out_free;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  // Loads with a round number past the last key are dropped.
  assign wr_en = in_acc && (action_i == ActLoad) &&
                 ({1'b0, key_round_i} <= 5'(ROUND_COUNT));
  // The registered key read is addressed one round ahead: rnd_q holds the round being applied.
  assign rd_addr = (state_q == StRun && !last_rnd) ? AddrW'(rnd_q + 1'b1) : '0;

  aes128_key_mem #(.ROUND_COUNT(ROUND_COUNT)) u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_half_i (key_half_i),
    .wr_addr_i (AddrW'(key_round_i)),
    .wr_data_i (data_high_i),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rkey)
  );

  assign last_rnd = (rnd_q == AddrW'(ROUND_COUNT));
  assign ss = sub_shift(st_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    st_d = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hi_d = out_hi_q;
    out_lo_d = out_lo_q;
    case (state_q)
      StIdle: begin
        if (in_acc && (action_i == ActEncrypt)) begin
          state_d = StRun;
          rnd_d = '0;
          st_d = {data_high_i, data_low_i};
        end
      end
      StRun: begin
        if (rnd_q == '0) begin
          st_d = st_q ^ rkey;
        end else if (last_rnd) begin
          st_d = ss ^ rkey;
        end else begin
          st_d = mix_cols(ss) ^ rkey;
        end
        rnd_d = AddrW'(rnd_q + 1'b1);
        if (last_rnd) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            {out_hi_d, out_lo_d} = ss ^ rkey;
            state_d = StIdle;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        // Finished block waits here until the output register drains.
        if (out_free) begin
          out_valid_d = 1'b1;
          {out_hi_d, out_lo_d} = st_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    out_hi_q <= out_hi_d;
    out_lo_q <= out_lo_d;
  end

  assign out_valid_o = out_valid_q;
  assign cipher_high_o = out_hi_q;
  assign cipher_low_o = out_lo_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_acc) else $error("beat taken while busy");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && last_rnd) |=> (state_q != StRun)) else $error("missed end of run");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
    (out_valid_o && $stable(cipher_high_o) && $stable(cipher_low_o)))
    else $error("result lost under stall");
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> out_valid_o) else $error("block waits on an empty output");
  a_start_round0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_acc && action_i == ActEncrypt) |=> (state_q == StRun && rnd_q == '0))
    else $error("bad start");

endmodule

@@ bench/aes128_block_encrypt_unit_test.sv @@
// Testbench for the AES-128 block encryption unit: directed and random beats, scoreboard check.
`timescale 1ns / 1ps
module aes128_block_encrypt_unit_test;
  import aes128_pkg::*;

  localparam int unsigned KeyWords = 2 * (RoundCount + 1);

  // Predicts ciphertext from its own copy of the round key store.
  class cipher_scoreboard;
    logic [WordW-1:0] key_store [KeyWords];
    logic [WordW-1:0] want_high [$];
    logic [WordW-1:0] want_low [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [7:0] sub_byte(logic [7:0] v);
      logic [7:0] inv, p, b;
      logic [7:0] r;
      // S-box built from the field inverse and the affine map.
      inv = 8'h00;
      for (int i = 1; i < 256; i++) begin
        p = 8'h00;
        b = i[7:0];
        for (int k = 0; k < 8; k++) begin
          if (v[k]) p = p ^ b;
          b = b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
        end
        if (p == 8'h01) inv = i[7:0];
      end
      for (int k = 0; k < 8; k++)
        r[k] = inv[k] ^ inv[(k + 4) % 8] ^ inv[(k + 5) % 8] ^ inv[(k + 6) % 8] ^
               inv[(k + 7) % 8];
      return r ^ 8'h63;
    endfunction

    function logic [7:0] xtime(logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
    endfunction

    function logic [127:0] encrypt(logic [127:0] pt);
      logic [127:0] s, t;
      logic [7:0] a0, a1, a2, a3, al;
      s = pt ^ {key_store[0], key_store[1]};
      for (int rnd = 1; rnd <= RoundCount; rnd++) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[127 - 8 * (4 * c + r) -: 8] = sub_byte(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
        s = t;
        if (rnd != RoundCount) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8]; a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8]; a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
          end
          s = t;
        end
        s = s ^ {key_store[2 * rnd], key_store[2 * rnd + 1]};
      end
      return s;
    endfunction

    function void note_beat(logic act, logic [KeyRoundW-1:0] rnd, logic half,
                            logic [WordW-1:0] hi, logic [WordW-1:0] lo);
      logic [127:0] ct;
      if (act == ActLoad) begin
        if (rnd <= RoundCount) key_store[2 * rnd + half] = hi;
      end else begin
        ct = encrypt({hi, lo});
        want_high.push_back(ct[127:64]);
        want_low.push_back(ct[63:0]);
      end
    endfunction

    function void check_result(logic [WordW-1:0] hi, logic [WordW-1:0] lo);
      logic [WordW-1:0] eh, el;
      if (want_high.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h", $time, hi, lo);
        return;
      end
      eh = want_high.pop_front();
      el = want_low.pop_front();
      if (hi !== eh) begin
        errors++;
        $display("%0t: cipher_high expected %h actual %h", $time, eh, hi);
      end
      if (lo !== el) begin
        errors++;
        $display("%0t: cipher_low expected %h actual %h", $time, el, lo);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = ActLoad;
  logic [KeyRoundW-1:0] key_round_i = '0;
  logic key_half_i = 1'b0;
  logic [WordW-1:0] data_high_i = '0;
  logic [WordW-1:0] data_low_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [WordW-1:0] cipher_high_o;
  logic [WordW-1:0] cipher_low_o;

  int send_idle_pct = 22;
  int recv_idle_pct = 67;
  cipher_scoreboard board = new();

  always #10 clk_i = ~clk_i;

  aes128_block_encrypt_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .key_round_i, .key_half_i,
    .data_high_i, .data_low_i, .out_valid_o, .out_stall_i, .cipher_high_o, .cipher_low_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(cipher_high_o, cipher_low_o);
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Drive one beat, holding it until accepted; optional random gap first.
  task automatic send_beat(logic act, logic [KeyRoundW-1:0] rnd, logic half,
                           logic [WordW-1:0] hi, logic [WordW-1:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    key_round_i <= rnd;
    key_half_i <= half;
    data_high_i <= hi;
    data_low_i <= lo;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(act, rnd, half, hi, lo);
    @(negedge clk_i);
  endtask

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic load_all_keys(bit random_keys);
    for (int r = 0; r <= RoundCount; r++)
      for (int h = 0; h < 2; h++)
        send_beat(ActLoad, r[KeyRoundW-1:0], h[0],
                  random_keys ? rand_word() : {WordW{r[0] ^ h[0]}}, rand_word());
  endtask

  task automatic random_beat();
    logic [KeyRoundW-1:0] rnd;
    logic half;
    int pick;
    pick = $urandom_range(99);
    half = 1'($urandom);
    if (pick < 80) begin
      send_beat(ActEncrypt, KeyRoundW'($urandom), half, rand_word(), rand_word());
    end else begin
      // Out-of-range rounds (11..15) must be ignored.
      rnd = (pick < 95) ? KeyRoundW'($urandom_range(RoundCount)) :
                          KeyRoundW'($urandom_range(15, RoundCount + 1));
      send_beat(ActLoad, rnd, half, rand_word(), rand_word());
    end
  endtask

  initial begin
    int waited;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: FIPS-197 appendix key schedule and vector.
    send_idle_pct = 0;
    begin
      logic [127:0] fips_keys [11] = '{
        128'h000102030405060708090a0b0c0d0e0f, 128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
        128'hb692cf0b643dbdf1be9bc5006830b3fe, 128'hb6ff744ed2c2c9bf6c590cbf0469bf41,
        128'h47f7f7bc95353e03f96c32bcfd058dfd, 128'h3caaa3e8a99f9deb50f3af57adf622aa,
        128'h5e390f7df7a69296a7553dc10aa31f6b, 128'h14f9701ae35fe28c440adf4d4ea9c026,
        128'h47438735a41c65b9e016baf4aebf7ad2, 128'h549932d1f08557681093ed9cbe2c974e,
        128'h13111d7fe3944a17f307a78b4d2b30c5};
      for (int r = 0; r <= RoundCount; r++) begin
        send_beat(ActLoad, r[KeyRoundW-1:0], 1'b0, fips_keys[r][127:64], '1);
        send_beat(ActLoad, r[KeyRoundW-1:0], 1'b1, fips_keys[r][63:0], '0);
      end
    end
    send_beat(ActEncrypt, 4'd0, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_beat(ActLoad, 4'd15, 1'b1, '1, '1);
    send_beat(ActLoad, 4'd11, 1'b0, '0, '1);
    send_beat(ActEncrypt, 4'd15, 1'b1, '0, '0);
    send_beat(ActEncrypt, 4'd0, 1'b0, '1, '1);
    send_beat(ActEncrypt, 4'd7, 1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_beat(ActEncrypt, 4'd8, 1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

    // Random phases: every key word written first so no unwritten entry is read.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 22 : 0;
      load_all_keys(phase != 1);
      for (int n = 0; n < 320; n++) random_beat();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (board.want_high.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (3 * RoundCount + 10) @(negedge clk_i);
    if (board.errors == 0 && board.want_high.size() == 0) begin
      $display("PASS aes128_block_encrypt_unit");
    end else begin
      $display("FAIL aes128_block_encrypt_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL aes128_block_encrypt_unit");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_key_mem.sv
hw/rtl/aes128_block_encrypt_unit.sv
bench/aes128_block_encrypt_unit_test.sv
